FILE: design/ctdn_pkg.sv
// Shared types and constants for the countdown timer bank display block.
// Holds the transaction structs, command codes and the sequencer microprogram.
// No dependencies.
`default_nettype none
package ctdn_pkg;

	// command codes
	localparam logic [1:0] CMD_SET     = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_REFRESH = 2'd2;

	// display rule constants
	localparam logic signed [15:0] SEC_PER_MIN = 16'sd60;
	localparam logic signed [15:0] MIN_CAP_SEC = 16'sd5940;
	localparam logic signed [7:0]  MIN_CAP     = 8'sd99;
	localparam logic signed [7:0]  BLANK_SHOWN = -8'sd1;
	localparam logic signed [15:0] BLANK_TIME  = -16'sd1;
	// ceil(2^20 / 60): exact quotient for every time up to the cap
	localparam logic [14:0] MIN_RECIP   = 15'd17477;
	localparam int          RECIP_SHIFT = 20;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [1:0]         row_sel;
		logic [1:0]         slot_sel;
		logic signed [15:0] seconds_in;
		logic               dot_in;
	} req_t;

	typedef struct packed {
		logic [1:0]        row_out;
		logic [1:0]        slot_out;
		logic signed [7:0] shown;
		logic              dot_out;
		logic              last;
	} upd_t;

	// microprogram addresses
	typedef logic [2:0] upc_t;
	localparam upc_t UPC_IDLE    = 3'd0;
	localparam upc_t UPC_SET     = 3'd1;
	localparam upc_t UPC_FLUSH   = 3'd2;
	localparam upc_t UPC_TICK_RD = 3'd3;
	localparam upc_t UPC_TICK    = 3'd4;
	localparam upc_t UPC_REF_RD  = 3'd5;
	localparam upc_t UPC_REF     = 3'd6;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_SET,
		EMIT_MEM
	} emit_t;

	typedef struct packed {
		logic  idle;   // wait for a request, dispatch on accept
		logic  rd;     // read the entry at the scan counter
		logic  set_wr; // write the latched set request
		logic  dec;    // count down the entry just read
		emit_t emit;   // result source
		logic  flush;  // release the held result as the last one
		logic  loop;   // repeat this step until the final entry
		upc_t  nxt;
	} uword_t;

	typedef struct packed {
		logic start;
		upc_t entry;
		logic go;
		logic at_last;
	} seq_ctl_t;

	function automatic uword_t ucode(input upc_t a);
		uword_t w;
		begin
			w = '{idle: 1'b0, rd: 1'b0, set_wr: 1'b0, dec: 1'b0, emit: EMIT_NONE,
				flush: 1'b0, loop: 1'b0, nxt: UPC_IDLE};
			case (a)
				UPC_IDLE: begin
					w.idle = 1'b1;
				end
				UPC_SET: begin
					w.set_wr = 1'b1;
					w.emit   = EMIT_SET;
					w.nxt    = UPC_FLUSH;
				end
				UPC_FLUSH: begin
					w.flush = 1'b1;
				end
				UPC_TICK_RD: begin
					w.rd  = 1'b1;
					w.nxt = UPC_TICK;
				end
				UPC_TICK: begin
					w.rd   = 1'b1;
					w.dec  = 1'b1;
					w.emit = EMIT_MEM;
					w.loop = 1'b1;
					w.nxt  = UPC_FLUSH;
				end
				UPC_REF_RD: begin
					w.rd  = 1'b1;
					w.nxt = UPC_REF;
				end
				UPC_REF: begin
					w.rd   = 1'b1;
					w.emit = EMIT_MEM;
					w.loop = 1'b1;
					w.nxt  = UPC_FLUSH;
				end
				default: begin
					w.idle = 1'b1;
				end
			endcase
			ucode = w;
		end
	endfunction

endpackage
`default_nettype wire

FILE: design/ctdn_seq.sv
// Microprogram sequencer: step counter plus the control ROM lookup.
// Depends on ctdn_pkg (control word, program addresses, ROM function).
`default_nettype none
module ctdn_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  ctdn_pkg::seq_ctl_t ctl,
	output ctdn_pkg::uword_t   word
);

	ctdn_pkg::upc_t upc_q;

	assign word = ctdn_pkg::ucode(upc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ctdn_pkg::UPC_IDLE;
		end else if (ctl.go) begin
			if (word.idle) begin
				if (ctl.start) begin
					upc_q <= ctl.entry;
				end
			end else if (!(word.loop && !ctl.at_last)) begin
				upc_q <= word.nxt;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/countdown_timer_bank_display.sv
// Countdown timer bank display. From the accept edge to the last update registered, a set
// takes a write step and a flush step; a tick or refresh takes one read step, one step per
// entry through the timer memory, and one flush step. One request at a time: req_stall is
// high from the accept edge until the sequencer idles, and upd_stall can hold any step that
// moves a result out.
// Reset (arst_n low) clears the entry valid bits: every timer reads blank (-1), dot clear.
`default_nettype none
module countdown_timer_bank_display #(
	parameter int ROWS  = 4,
	parameter int SLOTS = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  ctdn_pkg::req_t  req,
	output logic            upd_valid,
	input  wire             upd_stall,
	output ctdn_pkg::upd_t  upd
);

	localparam int ENTRIES = ROWS * SLOTS;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Display rule: blank for negative, seconds under a minute, minutes, capped.
	// Minutes come from a reciprocal multiply, exact for 0..5940.
	function automatic logic signed [7:0] disp(input logic signed [15:0] t);
		logic [27:0] prod;
		begin
			prod = 28'(t[12:0]) * 28'(ctdn_pkg::MIN_RECIP);
			if (t < 16'sd0)
				disp = ctdn_pkg::BLANK_SHOWN;
			else if (t < ctdn_pkg::SEC_PER_MIN)
				disp = $signed(t[7:0]);
			else if (t > ctdn_pkg::MIN_CAP_SEC)
				disp = ctdn_pkg::MIN_CAP;
			else
				disp = $signed(prod[ctdn_pkg::RECIP_SHIFT +: 8]);
		end
	endfunction

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	ctdn_pkg::seq_ctl_t seq_ctl;
	ctdn_pkg::uword_t   word;

	ctdn_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (seq_ctl),
		.word  (word)
	);

	// latched request, consumed by the set step
	ctdn_pkg::req_t req_q;

	// scan counters (read side) and the stage that holds the read entry
	logic [IDX_W-1:0] idx_q, idx_s1;
	logic [RW-1:0]    row_q, row_s1;
	logic [SW-1:0]    slot_q, slot_s1;

	// timer memory: {time, dot}; entries without a valid bit read as blank
	logic [16:0]        mem [ENTRIES];
	logic [16:0]        mem_rd_s1;
	logic               rd_vld_s1;
	logic [ENTRIES-1:0] vld_q;

	// one held result: it goes out once we know whether another follows
	logic           pend_vld_q;
	ctdn_pkg::upd_t pend_q;
	logic           out_vld_q;
	ctdn_pkg::upd_t out_q;
	logic [ctdn_pkg::CNT_W-1:0] cnt_q;

	logic               accept;
	logic               set_ok;
	logic signed [15:0] rd_time;
	logic               rd_dot;
	logic               t_pos;
	logic               at_last;
	logic               cnt_ok;
	logic               emit_now;
	ctdn_pkg::upd_t     emit_val;
	logic               need_push;
	logic               can_push;
	logic               go;
	logic               push;
	logic               emit_fire;
	logic               rd_en;
	logic               dec_wr;
	logic               set_wr;
	logic [IDX_W-1:0]   set_addr;

	assign req_stall = !word.idle;
	assign accept    = req_valid && !req_stall;
	assign set_ok    = (int'(req.row_sel) < ROWS) && (int'(req.slot_sel) < SLOTS);

	always_comb begin
		seq_ctl.go      = go;
		seq_ctl.at_last = at_last;
		seq_ctl.start   = 1'b0;
		seq_ctl.entry   = ctdn_pkg::UPC_IDLE;
		if (accept) begin
			case (req.cmd)
				ctdn_pkg::CMD_SET: begin
					seq_ctl.start = set_ok;
					seq_ctl.entry = ctdn_pkg::UPC_SET;
				end
				ctdn_pkg::CMD_TICK: begin
					seq_ctl.start = 1'b1;
					seq_ctl.entry = ctdn_pkg::UPC_TICK_RD;
				end
				ctdn_pkg::CMD_REFRESH: begin
					seq_ctl.start = 1'b1;
					seq_ctl.entry = ctdn_pkg::UPC_REF_RD;
				end
				default: begin
					seq_ctl.start = 1'b0;
				end
			endcase
		end
	end

	// entry under work
	assign rd_time = rd_vld_s1 ? $signed(mem_rd_s1[16:1]) : ctdn_pkg::BLANK_TIME;
	assign rd_dot  = rd_vld_s1 && mem_rd_s1[0];
	assign t_pos   = rd_time > 16'sd0;
	assign at_last = (int'(idx_s1) == ENTRIES - 1);
	assign cnt_ok  = int'(cnt_q) < ctdn_pkg::MAX_RESULTS;

	always_comb begin
		emit_now = 1'b0;
		emit_val = '0;
		case (word.emit)
			ctdn_pkg::EMIT_SET: begin
				emit_now          = 1'b1;
				emit_val.row_out  = req_q.row_sel;
				emit_val.slot_out = req_q.slot_sel;
				emit_val.shown    = disp(req_q.seconds_in);
				emit_val.dot_out  = req_q.dot_in;
			end
			ctdn_pkg::EMIT_MEM: begin
				// a tick only reports the timers it lowered
				emit_now          = !word.dec || t_pos;
				emit_val.row_out  = 2'(row_s1);
				emit_val.slot_out = 2'(slot_s1);
				emit_val.shown    = disp(word.dec ? rd_time - 16'sd1 : rd_time);
				emit_val.dot_out  = rd_dot;
			end
			default: begin
				emit_now = 1'b0;
			end
		endcase
	end

	// a step that moves the held result out waits for room in the output register
	assign need_push = pend_vld_q && ((emit_now && cnt_ok) || word.flush);
	assign can_push  = !out_vld_q || !upd_stall;
	assign go        = !need_push || can_push;
	assign push      = go && need_push;
	assign emit_fire = go && emit_now && cnt_ok;

	assign rd_en    = go && word.rd && !(word.loop && at_last);
	assign dec_wr   = go && word.dec && t_pos;
	assign set_wr   = go && word.set_wr;
	assign set_addr = IDX_W'(int'(req_q.row_sel) * SLOTS + int'(req_q.slot_sel));

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (set_wr) begin
			mem[set_addr] <= {req_q.seconds_in, req_q.dot_in};
		end else if (dec_wr) begin
			mem[idx_s1] <= {rd_time - 16'sd1, rd_dot};
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rd_en) begin
			idx_s1  <= idx_q;
			row_s1  <= row_q;
			slot_s1 <= slot_q;
		end
		if (emit_fire) begin
			pend_q <= emit_val;
		end
		if (push) begin
			out_q.row_out  <= pend_q.row_out;
			out_q.slot_out <= pend_q.slot_out;
			out_q.shown    <= pend_q.shown;
			out_q.dot_out  <= pend_q.dot_out;
			out_q.last     <= word.flush;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			idx_q      <= '0;
			row_q      <= '0;
			slot_q     <= '0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (set_wr) begin
				vld_q[set_addr] <= 1'b1;
			end
			if (seq_ctl.start) begin
				idx_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
				cnt_q  <= '0;
			end else if (rd_en) begin
				rd_vld_s1 <= vld_q[idx_q];
				idx_q     <= idx_q + 1'b1;
				if (int'(slot_q) == SLOTS - 1) begin
					slot_q <= '0;
					row_q  <= row_q + 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (emit_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (go && word.flush) begin
				pend_vld_q <= 1'b0;
			end else if (emit_fire) begin
				pend_vld_q <= 1'b1;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (!upd_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign upd_valid = out_vld_q;
	assign upd       = out_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// nothing is left behind when a new request may come in
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> !pend_vld_q)
		else $error("held result left over while idle");

	// a held result always counts against the result cap
	a_pend_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> cnt_q != '0)
		else $error("held result without a count");

	// the flush step releases the held result marked as last
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go && word.flush && pend_vld_q) |=> (upd_valid && upd.last))
		else $error("flush did not release a last result");

	// an unused command leaves the block idle
	a_unused_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd != ctdn_pkg::CMD_SET && req.cmd != ctdn_pkg::CMD_TICK &&
		 req.cmd != ctdn_pkg::CMD_REFRESH) |=> !req_stall)
		else $error("unused command started the sequencer");

endmodule
`default_nettype wire

FILE: tb/sv/ctdn_checker.sv
// Scoreboard for the countdown timer bank display: watches both channels,
// keeps its own timer table and checks every display update in order.
// Depends on ctdn_pkg (req_t, upd_t, command codes).
module ctdn_checker
	import ctdn_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	input  wire  req_stall,
	input  req_t req,
	input  wire  upd_valid,
	input  wire  upd_stall,
	input  upd_t upd,
	output int   fail_count,
	output int   pending
);

	localparam int N_ROWS      = 4;
	localparam int N_SLOTS     = 4;
	localparam int N_TIMERS    = N_ROWS * N_SLOTS;
	localparam int MINUTE      = 60;
	localparam int CAP_MINUTES = 99;
	localparam logic signed [15:0] BLANK_SECS  = -16'sd1;
	localparam logic signed [7:0]  BLANK_SHOWN = -8'sd1;

	logic signed [15:0] timer_secs [N_TIMERS];
	logic               timer_dot  [N_TIMERS];
	upd_t               expected_upds [$];
	int                 n_fail = 0;
	int                 n_pending = 0;

	assign fail_count = n_fail;
	assign pending    = n_pending;

	function automatic logic signed [7:0] display_of(input logic signed [15:0] secs);
		int s;
		s = secs;
		if (s < 0)
			return BLANK_SHOWN;
		if (s < MINUTE)
			return 8'(s);
		if (s > CAP_MINUTES * MINUTE)
			return 8'(CAP_MINUTES);
		return 8'(s / MINUTE);
	endfunction

	function automatic upd_t entry_upd(input int idx);
		upd_t u;
		u.row_out  = 2'(idx / N_SLOTS);
		u.slot_out = 2'(idx % N_SLOTS);
		u.shown    = display_of(timer_secs[idx]);
		u.dot_out  = timer_dot[idx];
		u.last     = 1'b0;
		return u;
	endfunction

	task automatic predict_timers(input req_t r);
		int   idx;
		int   n_before;
		upd_t u;
		n_before = expected_upds.size();
		case (r.cmd)
			CMD_SET: begin
				if (r.row_sel < N_ROWS && r.slot_sel < N_SLOTS) begin
					idx = r.row_sel * N_SLOTS + r.slot_sel;
					timer_secs[idx] = r.seconds_in;
					timer_dot[idx]  = r.dot_in;
					expected_upds.push_back(entry_upd(idx));
				end
			end
			CMD_TICK: begin
				for (idx = 0; idx < N_TIMERS; idx++) begin
					if (timer_secs[idx] > 0) begin
						timer_secs[idx] = timer_secs[idx] - 16'sd1;
						expected_upds.push_back(entry_upd(idx));
					end
				end
			end
			CMD_REFRESH: begin
				for (idx = 0; idx < N_TIMERS; idx++)
					expected_upds.push_back(entry_upd(idx));
			end
			default: ;
		endcase
		// mark the final update of this transaction
		if (expected_upds.size() > n_before) begin
			u = expected_upds.pop_back();
			u.last = 1'b1;
			expected_upds.push_back(u);
		end
	endtask

	task automatic check_upd(input upd_t got);
		upd_t want;
		if (expected_upds.size() == 0) begin
			$error("unexpected update: row %0d slot %0d shown %0d dot %0d last %0d",
				got.row_out, got.slot_out, got.shown, got.dot_out, got.last);
			n_fail++;
			return;
		end
		want = expected_upds.pop_front();
		if (got.row_out !== want.row_out) begin
			$error("row_out: expected %0d, got %0d", want.row_out, got.row_out);
			n_fail++;
		end
		if (got.slot_out !== want.slot_out) begin
			$error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
			n_fail++;
		end
		if (got.shown !== want.shown) begin
			$error("shown: expected %0d, got %0d", want.shown, got.shown);
			n_fail++;
		end
		if (got.dot_out !== want.dot_out) begin
			$error("dot_out: expected %0d, got %0d", want.dot_out, got.dot_out);
			n_fail++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			n_fail++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_TIMERS; i++) begin
				timer_secs[i] = BLANK_SECS;
				timer_dot[i]  = 1'b0;
			end
			expected_upds.delete();
		end else begin
			// an update never belongs to a request taken on the same edge
			if (upd_valid && !upd_stall)
				check_upd(upd);
			if (req_valid && !req_stall)
				predict_timers(req);
		end
		n_pending = expected_upds.size();
	end

endmodule

FILE: tb/sv/tb_countdown_timer_bank_display.sv
// Top of the countdown timer bank display testbench: clock, reset, stimulus
// and verdict. Depends on ctdn_pkg, the block and ctdn_checker.
module tb_countdown_timer_bank_display;
	import ctdn_pkg::*;

	// the block decodes only three commands; the fourth must be dropped
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// random phase; with the directed list this comes to about 450 transactions
	localparam int N_RANDOM = 426;
	localparam logic signed [15:0] BLANK_SECS = -16'sd1;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY
	} stall_mode_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic upd_valid;
	logic upd_stall;
	upd_t upd;
	int   fail_count;
	int   pending;

	countdown_timer_bank_display dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.upd_valid (upd_valid),
		.upd_stall (upd_stall),
		.upd       (upd)
	);

	// scoreboard sits beside the block and only watches
	ctdn_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.upd_valid  (upd_valid),
		.upd_stall  (upd_stall),
		.upd        (upd),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop; the slowest legal run is far below this
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic req_t set_req(input int row, input int slot,
		input logic signed [15:0] secs, input logic dot);
		req_t r;
		r.cmd        = CMD_SET;
		r.row_sel    = 2'(row);
		r.slot_sel   = 2'(slot);
		r.seconds_in = secs;
		r.dot_in     = dot;
		return r;
	endfunction

	// non-set commands carry random junk in the other fields
	function automatic req_t cmd_req(input logic [1:0] cmd);
		req_t r;
		r.cmd        = cmd;
		r.row_sel    = 2'($urandom_range(0, 3));
		r.slot_sel   = 2'($urandom_range(0, 3));
		r.seconds_in = 16'($urandom);
		r.dot_in     = 1'($urandom);
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r = set_req($urandom_range(0, 3), $urandom_range(0, 3), 16'sd0,
				1'($urandom));
			// mostly short times so ticks walk them through zero and the
			// minute/second boundary; some near the 99 minute cap
			pick = $urandom_range(0, 99);
			if (pick < 55)
				r.seconds_in = 16'($urandom_range(0, 130));
			else if (pick < 70)
				r.seconds_in = 16'($urandom_range(5930, 5950));
			else if (pick < 80)
				r.seconds_in = BLANK_SECS;
			else
				r.seconds_in = 16'($urandom);
		end else if (pick < 80) begin
			r = cmd_req(CMD_TICK);
		end else if (pick < 92) begin
			r = cmd_req(CMD_REFRESH);
		end else begin
			r = cmd_req(CMD_UNUSED);
		end
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the accept
	task automatic drive_item(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// waits on a falling edge before the first check, so valid is never lowered and raised in one step
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// receiver: stall pattern switches between quiet, light and heavy runs
	initial begin
		stall_mode_t mode;
		int          seg_len;
		upd_stall = 1'b0;
		forever begin
			mode    = stall_mode_t'($urandom_range(0, 2));
			seg_len = $urandom_range(20, 200);
			repeat (seg_len) begin
				@(negedge clk);
				case (mode)
					STALL_NONE: begin
						upd_stall <= 1'b0;
					end
					STALL_LIGHT: begin
						upd_stall <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						upd_stall <= ($urandom_range(0, 9) < 7);
					end
				endcase
			end
		end
	end

	// sender
	initial begin
		req_t directed [$];
		req_t r;
		int   sent;
		int   burst;
		int   gap;
		bit   drain;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: blank table, empty tick, dropped command, then the
		// display boundaries, negative times and the signed extremes
		directed.push_back(cmd_req(CMD_REFRESH));
		directed.push_back(cmd_req(CMD_TICK));
		directed.push_back(cmd_req(CMD_UNUSED));
		directed.push_back(set_req(0, 0, 16'sd0, 1'b1));
		directed.push_back(set_req(3, 3, 16'sd32767, 1'b0));
		directed.push_back(set_req(0, 1, 16'sd5940, 1'b1));
		directed.push_back(set_req(0, 2, 16'sd5941, 1'b0));
		directed.push_back(set_req(0, 3, 16'sd59, 1'b1));
		directed.push_back(set_req(1, 0, 16'sd60, 1'b0));
		directed.push_back(set_req(1, 1, BLANK_SECS, 1'b1));
		directed.push_back(set_req(1, 2, -16'sd32768, 1'b1));
		directed.push_back(set_req(1, 3, 16'sd1, 1'b0));
		directed.push_back(set_req(2, 0, 16'sd119, 1'b1));
		directed.push_back(set_req(2, 1, 16'sd5999, 1'b0));
		directed.push_back(set_req(2, 2, 16'sd61, 1'b1));
		directed.push_back(set_req(2, 3, 16'sh5555, 1'b0));
		directed.push_back(set_req(3, 0, 16'shAAAA, 1'b1));
		directed.push_back(set_req(3, 1, -16'sd2, 1'b0));
		directed.push_back(cmd_req(CMD_TICK));
		directed.push_back(cmd_req(CMD_TICK));
		directed.push_back(cmd_req(CMD_REFRESH));
		directed.push_back(cmd_req(CMD_UNUSED));
		directed.push_back(cmd_req(CMD_TICK));
		directed.push_back(cmd_req(CMD_REFRESH));
		foreach (directed[i])
			drive_item(directed[i]);

		// hold off until the table has been fully reported
		req_valid <= 1'b0;
		wait_drained();

		// random bursts; every transaction counts toward the total
		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				r = random_req();
				drive_item(r);
				sent++;
			end
			drain = ($urandom_range(0, 7) == 0);
			gap   = $urandom_range(0, 6);
			if (drain) begin
				req_valid <= 1'b0;
				wait_drained();
			end else if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end

		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// let any stray trailing update show up
		repeat (40) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
